### rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of the topology table.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RTE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define RTE_ASSERT_CK(lbl, prop, msg) \
  `RTE_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/rte_pkg.sv
// -----------------------------------------------------------------------------
// rte_pkg
// Types and constants of the routing topology table engine.
// -----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  localparam int SLOT_W   = 6;
  localparam int FLAG_W   = 3;
  localparam int DIST_W   = 32;
  localparam int STATUS_W = 2;

  // Flag bit positions in the flag store.
  localparam int FL_OCC   = 0;
  localparam int FL_VALID = 1;
  localparam int FL_SUCC  = 2;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FEAS   = 3'd3,
    OP_BEST   = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_DRAIN,
    S_FINISH
  } state_e;

  // One table row apart from its flags.
  typedef struct packed {
    logic [9:0]        route_id;
    logic [7:0]        next_hop_id;
    logic [31:0]       addr;
    logic [7:0]        iface;
    logic [DIST_W-1:0] metric;
    logic [DIST_W-1:0] reported;
  } entry_t;

  typedef struct packed {
    logic clr;   // restart the accumulators
    logic proc;  // read data of one entry is present
  } scan_ctl_t;

  typedef struct packed {
    logic              match_hit;
    logic              free_hit;
    logic              best_hit;
    logic              feas_hit;
    logic [DIST_W-1:0] match_metric;
    logic [DIST_W-1:0] best_metric;
    logic [DIST_W-1:0] dmin;
  } scan_res_t;

endpackage

`default_nettype wire

### rtl/routing_topology_table_engine.sv
// -----------------------------------------------------------------------------
// routing_topology_table_engine
// Table of route sources with insert, update, remove, find, best successor
// and feasibility search, kept in two synchronous RAMs and scanned entry by
// entry.
//
//   channel  dir  handshake                beat contents
//   in       in   in_valid_i / in_stall_o  request type, slot, key, row data, FD
//   out      out  out_valid_o / out_stall_i status, hit, slot, distance
//
// Searching requests pass through accept, one RAM read per entry, a drain
// of the read port and a final step that writes back and registers the
// result, held while an earlier result is stalled. Update and remove read
// their slot between accept and final step; an unknown request reads none.
// After reset a clearing pass zeroes every flag RAM entry while in_stall_o
// stays high; a stalled result holds off the next result, not the next accept.
// -----------------------------------------------------------------------------
`default_nettype none

module routing_topology_table_engine #(
  parameter int ENTRIES = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [2:0]                     req_type_i,
  input  wire logic [rte_pkg::SLOT_W-1:0]     slot_i,
  input  wire logic [9:0]                     route_id_i,
  input  wire logic [7:0]                     next_hop_id_i,
  input  wire logic [31:0]                    next_hop_addr_i,
  input  wire logic [7:0]                     iface_id_i,
  input  wire logic [rte_pkg::DIST_W-1:0]     metric_in_i,
  input  wire logic [rte_pkg::DIST_W-1:0]     reported_in_i,
  input  wire logic [rte_pkg::DIST_W-1:0]     feasible_distance_i,
  input  wire logic                           is_successor_i,
  input  wire logic                           is_valid_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [rte_pkg::STATUS_W-1:0]   status_o,
  output logic                                hit_o,
  output logic      [rte_pkg::SLOT_W-1:0]     slot_out_o,
  output logic      [rte_pkg::DIST_W-1:0]     distance_o
);
  import rte_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_e state_q, state_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          proc_vld_q;
  logic [IW-1:0] proc_idx_q;

  // Request held for the duration of one beat.
  op_e               req_q;
  logic [SLOT_W-1:0] slot_q;
  entry_t            req_entry_q;
  logic [DIST_W-1:0] fd_q;
  logic              succ_q, valid_q;

  logic [IW-1:0] slot_idx;
  logic          slot_ok;

  // RAM ports.
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic              fl_we, pl_we;
  logic [IW-1:0]     fl_waddr, pl_waddr;
  logic [FLAG_W-1:0] fl_wdata, fl_rdata;
  entry_t            pl_rdata;

  scan_ctl_t     scan_ctl;
  scan_res_t     scan_res;
  logic [IW-1:0] match_idx, free_idx, best_idx;

  // Result register.
  logic                out_valid_q, out_valid_d, out_load;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                hit_q, hit_d;
  logic [SLOT_W-1:0]   slot_out_q, slot_out_d;
  logic [DIST_W-1:0]   distance_q, distance_d;

  assign slot_idx = IW'(slot_q);
  assign slot_ok  = (32'(slot_q) < 32'(ENTRIES));

  rte_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (ENTRIES)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (fl_rdata)
  );

  rte_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (req_entry_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (pl_rdata)
  );

  rte_scan #(
    .ENTRIES (ENTRIES)
  ) u_rte_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .idx_i         (proc_idx_q),
    .flags_i       (fl_rdata),
    .entry_i       (pl_rdata),
    .route_id_i    (req_entry_q.route_id),
    .next_hop_id_i (req_entry_q.next_hop_id),
    .fd_i          (fd_q),
    .res_o         (scan_res),
    .match_idx_o   (match_idx),
    .free_idx_o    (free_idx),
    .best_idx_o    (best_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rd_idx_q    <= '0;
      proc_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      proc_vld_q  <= (state_q == S_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= rd_idx_q;
    if (in_valid_i && !in_stall_o) begin
      req_q                   <= op_e'(req_type_i);
      slot_q                  <= slot_i;
      req_entry_q.route_id    <= route_id_i;
      req_entry_q.next_hop_id <= next_hop_id_i;
      req_entry_q.addr        <= next_hop_addr_i;
      req_entry_q.iface       <= iface_id_i;
      req_entry_q.metric      <= metric_in_i;
      req_entry_q.reported    <= reported_in_i;
      fd_q                    <= feasible_distance_i;
      succ_q                  <= is_successor_i;
      valid_q                 <= is_valid_i;
    end
    if (out_load) begin
      status_q   <= status_d;
      hit_q      <= hit_d;
      slot_out_q <= slot_out_d;
      distance_q <= distance_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    rd_idx_d      = rd_idx_q;
    in_stall_o    = 1'b1;
    scan_ctl.clr  = 1'b0;
    scan_ctl.proc = proc_vld_q;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_q;
    fl_we         = 1'b0;
    fl_waddr      = rd_idx_q;
    fl_wdata      = '0;
    pl_we         = 1'b0;
    pl_waddr      = slot_idx;
    out_load      = 1'b0;
    status_d      = STATUS_NOT_FOUND;
    hit_d         = 1'b0;
    slot_out_d    = '0;
    distance_d    = DIST_INF;

    unique case (state_q)
      S_CLEAR: begin
        fl_we    = 1'b1;
        rd_idx_d = rd_idx_q + IW'(1);
        if (rd_idx_q == LAST_IDX) begin
          rd_idx_d = '0;
          state_d  = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          scan_ctl.clr = 1'b1;
          unique case (op_e'(req_type_i)) inside
            OP_INSERT, OP_FEAS, OP_BEST, OP_FIND: state_d = S_SCAN;
            OP_UPDATE, OP_REMOVE:                 state_d = S_SLOT;
            default:                              state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        ram_re   = 1'b1;
        rd_idx_d = rd_idx_q + IW'(1);
        if (rd_idx_q == LAST_IDX) begin
          rd_idx_d = '0;
          state_d  = S_DRAIN;
        end
      end
      S_SLOT: begin
        ram_re    = 1'b1;
        ram_raddr = slot_idx;
        state_d   = S_FINISH;
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // The write-back happens together with the result, so the next beat
        // never reads a row that is still being changed.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          unique case (req_q)
            OP_INSERT: begin
              if (scan_res.match_hit) begin
                status_d   = STATUS_OK;
                hit_d      = 1'b1;
                slot_out_d = SLOT_W'(match_idx);
                distance_d = scan_res.match_metric;
              end else if (scan_res.free_hit) begin
                fl_we              = 1'b1;
                fl_waddr           = free_idx;
                fl_wdata[FL_OCC]   = 1'b1;
                fl_wdata[FL_VALID] = 1'b1;
                fl_wdata[FL_SUCC]  = succ_q;
                pl_we              = 1'b1;
                pl_waddr           = free_idx;
                status_d           = STATUS_OK;
                slot_out_d         = SLOT_W'(free_idx);
                distance_d         = req_entry_q.metric;
              end else begin
                status_d = STATUS_FULL;
              end
            end
            OP_UPDATE: begin
              if (slot_ok && fl_rdata[FL_OCC]) begin
                fl_we              = 1'b1;
                fl_waddr           = slot_idx;
                fl_wdata[FL_OCC]   = 1'b1;
                fl_wdata[FL_VALID] = valid_q;
                fl_wdata[FL_SUCC]  = succ_q;
                pl_we              = 1'b1;
                status_d           = STATUS_OK;
                hit_d              = 1'b1;
                slot_out_d         = slot_q;
                distance_d         = req_entry_q.metric;
              end
            end
            OP_REMOVE: begin
              if (slot_ok && fl_rdata[FL_OCC]) begin
                fl_we      = 1'b1;
                fl_waddr   = slot_idx;
                status_d   = STATUS_OK;
                slot_out_d = slot_q;
              end
            end
            OP_FEAS: begin
              status_d   = STATUS_OK;
              hit_d      = scan_res.feas_hit;
              distance_d = scan_res.dmin;
            end
            OP_BEST: begin
              if (scan_res.best_hit) begin
                status_d   = STATUS_OK;
                hit_d      = 1'b1;
                slot_out_d = SLOT_W'(best_idx);
                distance_d = scan_res.best_metric;
              end
            end
            OP_FIND: begin
              if (scan_res.match_hit) begin
                status_d   = STATUS_OK;
                hit_d      = 1'b1;
                slot_out_d = SLOT_W'(match_idx);
                distance_d = scan_res.match_metric;
              end
            end
            default: begin
              status_d = STATUS_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_o       = hit_q;
  assign slot_out_o  = slot_out_q;
  assign distance_o  = distance_q;

endmodule

`default_nettype wire

### rtl/rte_ram.sv
// -----------------------------------------------------------------------------
// rte_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
`default_nettype none

module rte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/rte_scan.sv
// -----------------------------------------------------------------------------
// rte_scan
// Per-entry search logic: exact match, first free slot, minimum distance with
// feasibility, and best successor, accumulated over one pass of the table.
// -----------------------------------------------------------------------------
`default_nettype none

module rte_scan #(
  parameter int ENTRIES = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rte_pkg::scan_ctl_t           ctl_i,
  input  wire logic [$clog2(ENTRIES)-1:0]   idx_i,
  input  wire logic [rte_pkg::FLAG_W-1:0]   flags_i,
  input  wire rte_pkg::entry_t              entry_i,
  input  wire logic [9:0]                   route_id_i,
  input  wire logic [7:0]                   next_hop_id_i,
  input  wire logic [rte_pkg::DIST_W-1:0]   fd_i,
  output rte_pkg::scan_res_t                res_o,
  output logic      [$clog2(ENTRIES)-1:0]   match_idx_o,
  output logic      [$clog2(ENTRIES)-1:0]   free_idx_o,
  output logic      [$clog2(ENTRIES)-1:0]   best_idx_o
);
  import rte_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic              match_hit_q, free_hit_q, best_hit_q, feas_hit_q;
  logic [IW-1:0]     match_idx_q, free_idx_q, best_idx_q;
  logic [DIST_W-1:0] match_metric_q, best_metric_q, best_addr_q, dmin_q;

  logic live, rmatch, kmatch, below_fd;

  assign live     = flags_i[FL_OCC] && flags_i[FL_VALID];
  assign rmatch   = (entry_i.route_id == route_id_i);
  assign kmatch   = rmatch && (entry_i.next_hop_id == next_hop_id_i);
  assign below_fd = (entry_i.reported < fd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
      feas_hit_q  <= 1'b0;
      dmin_q      <= DIST_INF;
    end else if (ctl_i.clr) begin
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
      feas_hit_q  <= 1'b0;
      dmin_q      <= DIST_INF;
    end else if (ctl_i.proc) begin
      if (!match_hit_q && live && kmatch) begin
        match_hit_q <= 1'b1;
      end
      if (!free_hit_q && !flags_i[FL_OCC]) begin
        free_hit_q <= 1'b1;
      end
      // A strictly lower metric restarts the feasibility flag at this source.
      if (live && rmatch) begin
        if (entry_i.metric < dmin_q) begin
          dmin_q     <= entry_i.metric;
          feas_hit_q <= below_fd;
        end else if (entry_i.metric == dmin_q && below_fd) begin
          feas_hit_q <= 1'b1;
        end
      end
      if (live && flags_i[FL_SUCC] && rmatch) begin
        best_hit_q <= 1'b1;
      end
    end
  end

  // Payload of the winners; only meaningful once the matching hit flag is set.
  always_ff @(posedge clk_i) begin
    if (ctl_i.proc) begin
      if (!match_hit_q && live && kmatch) begin
        match_idx_q    <= idx_i;
        match_metric_q <= entry_i.metric;
      end
      if (!free_hit_q && !flags_i[FL_OCC]) begin
        free_idx_q <= idx_i;
      end
      // Ties on metric and address keep the earlier, lower slot.
      if (live && flags_i[FL_SUCC] && rmatch) begin
        if (!best_hit_q || entry_i.metric < best_metric_q ||
            (entry_i.metric == best_metric_q && entry_i.addr < best_addr_q)) begin
          best_idx_q    <= idx_i;
          best_metric_q <= entry_i.metric;
          best_addr_q   <= entry_i.addr;
        end
      end
    end
  end

  always_comb begin
    res_o.match_hit    = match_hit_q;
    res_o.free_hit     = free_hit_q;
    res_o.best_hit     = best_hit_q;
    res_o.feas_hit     = feas_hit_q;
    res_o.match_metric = match_metric_q;
    res_o.best_metric  = best_metric_q;
    res_o.dmin         = dmin_q;
  end

  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;
  assign best_idx_o  = best_idx_q;

endmodule

`default_nettype wire

### rtl/rte_checker.sv
// -----------------------------------------------------------------------------
// rte_checker
// Port-level checks of the routing topology table engine, bound to the top.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rte_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [rte_pkg::STATUS_W-1:0] status_o,
  input wire logic                         hit_o,
  input wire logic [rte_pkg::SLOT_W-1:0]   slot_out_o,
  input wire logic [rte_pkg::DIST_W-1:0]   distance_o
);
  import rte_pkg::*;

  // One beat is worked on at a time, so an accept always leaves the block busy.
  `RTE_ASSERT_CK(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "beat taken while busy")

  // A full table reports no slot and an infinite distance.
  `RTE_ASSERT_CK(a_full_shape, out_valid_o && status_o == STATUS_FULL |-> !hit_o && slot_out_o == '0 && distance_o == DIST_INF, "bad table full result")

  // Hit is only reported together with an ok status.
  `RTE_ASSERT_CK(a_hit_ok, out_valid_o && hit_o |-> status_o == STATUS_OK, "hit with error status")

  // A stalled result beat holds.
  `RTE_ASSERT_CK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o) && $stable(slot_out_o) && $stable(status_o), "stalled result changed")

endmodule

bind routing_topology_table_engine rte_checker u_rte_checker (.*);

`default_nettype wire
